>>> hdl/idrm_pkg.sv
`timescale 1ns / 1ps

package idrm_pkg;

	// Rounding mode carried on the opcode field
	typedef enum logic [1:0] {
		MODE_FLOOR = 2'd0,
		MODE_CEIL  = 2'd1,
		MODE_TRUNC = 2'd2,
		MODE_RNE   = 2'd3
	} mode_t;

	// Result status
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	// Per-item control that rides alongside the divider chain
	typedef struct packed {
		mode_t mode;
		logic  xneg;  // dividend negative
		logic  neg;   // operand signs differ
		err_t  err;
	} side_t;

endpackage

>>> hdl/idrm_div_stage.sv
`timescale 1ns / 1ps

// One restoring step of the unsigned divider, registered.
module idrm_div_stage
	import idrm_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         valid_i,
	input  logic [W-1:0] rem_i,
	input  logic [W-1:0] acc_i,
	input  logic [W-1:0] uy_i,
	input  side_t        side_i,
	output logic         valid_o,
	output logic [W-1:0] rem_o,
	output logic [W-1:0] acc_o,
	output logic [W-1:0] uy_o,
	output side_t        side_o
);

	logic [W:0]   shifted;
	logic [W:0]   trial;
	logic         qbit;
	logic [W-1:0] rem_nxt;

	// Shift in the next dividend bit and try subtracting the divisor
	always_comb begin
		shifted = {rem_i, acc_i[W-1]};
		trial   = shifted - {1'b0, uy_i};
		qbit    = ~trial[W];
		rem_nxt = qbit ? trial[W-1:0] : shifted[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= rem_nxt;
			acc_o  <= {acc_i[W-2:0], qbit};
			uy_o   <= uy_i;
			side_o <= side_i;
		end
	end

endmodule

>>> hdl/integer_divide_rounding_modes.sv
`timescale 1ns / 1ps

// Pipelined signed divider with floor, ceiling, truncate and round-half-even
// modes. One transfer is accepted every cycle while the pipe is not held;
// each result passes through one sign/check stage, one restoring divide step
// per quotient bit, one rounding stage and the output register. The whole pipe
// holds while a finished result waits on out_ready. A zero divisor returns
// error_code 1 and the most negative dividend over -1 returns error_code 2,
// both with zero quotient and remainder.
module integer_divide_rounding_modes
	import idrm_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic signed [DATA_WIDTH-1:0] remainder,
	output logic [1:0]                   error_code
);

	localparam int W = DATA_WIDTH;

	logic en;

	// Stage 1: signs, magnitudes, error checks
	logic         valid_s1;
	logic [W-1:0] ux_s1;
	logic [W-1:0] uy_s1;
	side_t        side_s1;

	// Divider chain, index 0 is stage 1
	logic         div_valid [0:W];
	logic [W-1:0] div_rem   [0:W];
	logic [W-1:0] div_acc   [0:W];
	logic [W-1:0] div_uy    [0:W];
	side_t        div_side  [0:W];

	// Rounding stage
	logic         valid_s2;
	logic [W-1:0] qmag_s2;
	logic [W-1:0] rmag_s2;
	logic         qneg_s2;
	logic         rneg_s2;
	err_t         err_s2;

	logic out_valid_q;

	// Pipe advances unless a result is stuck at the output
	assign en        = ~out_valid_q | out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;

	// Operand prep
	logic  xneg_c;
	logic  yneg_c;
	logic  dz_c;
	logic  ovf_c;
	side_t side_c;

	always_comb begin
		xneg_c      = dividend[W-1];
		yneg_c      = divisor[W-1];
		dz_c        = (divisor == '0);
		ovf_c       = (dividend == {1'b1, {(W-1){1'b0}}}) && (divisor == '1);
		side_c.mode = mode_t'(opcode);
		side_c.xneg = xneg_c;
		side_c.neg  = xneg_c ^ yneg_c;
		side_c.err  = dz_c ? ERR_DIV_ZERO : (ovf_c ? ERR_OVERFLOW : ERR_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1   <= xneg_c ? (~dividend + 1'b1) : dividend;
			uy_s1   <= yneg_c ? (~divisor + 1'b1) : divisor;
			side_s1 <= side_c;
		end
	end

	assign div_valid[0] = valid_s1;
	assign div_rem[0]   = '0;
	assign div_acc[0]   = ux_s1;
	assign div_uy[0]    = uy_s1;
	assign div_side[0]  = side_s1;

	// One quotient bit per stage, MSB first
	for (genvar i = 0; i < W; i++) begin : g_div
		idrm_div_stage #(
			.W(W)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (div_valid[i]),
			.rem_i   (div_rem[i]),
			.acc_i   (div_acc[i]),
			.uy_i    (div_uy[i]),
			.side_i  (div_side[i]),
			.valid_o (div_valid[i+1]),
			.rem_o   (div_rem[i+1]),
			.acc_o   (div_acc[i+1]),
			.uy_o    (div_uy[i+1]),
			.side_o  (div_side[i+1])
		);
	end

	// Rounding decision on the truncated magnitudes
	logic [W-1:0] uq_c;
	logic [W-1:0] ur_c;
	logic [W-1:0] dist_c;
	logic         away_c;
	side_t        side_f;

	always_comb begin
		uq_c   = div_acc[W];
		ur_c   = div_rem[W];
		side_f = div_side[W];
		dist_c = div_uy[W] - ur_c;
		away_c = 1'b0;
		if (ur_c != '0) begin
			case (side_f.mode)
				MODE_FLOOR: away_c = side_f.neg;
				MODE_CEIL:  away_c = ~side_f.neg;
				MODE_TRUNC: away_c = 1'b0;
				MODE_RNE:   away_c = (dist_c < ur_c) || ((dist_c == ur_c) && uq_c[0]);
				default:    away_c = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= div_valid[W];
		end
	end

	// Moving away from zero flips the remainder to the divisor's far side
	always_ff @(posedge clk) begin
		if (en) begin
			qmag_s2 <= uq_c + {{(W-1){1'b0}}, away_c};
			rmag_s2 <= away_c ? dist_c : ur_c;
			qneg_s2 <= side_f.neg;
			rneg_s2 <= side_f.xneg ^ away_c;
			err_s2  <= side_f.err;
		end
	end

	// Output register: apply signs, zero on error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (err_s2 != ERR_NONE) begin
				quotient  <= '0;
				remainder <= '0;
			end else begin
				quotient  <= qneg_s2 ? (~qmag_s2 + 1'b1) : qmag_s2;
				remainder <= rneg_s2 ? (~rmag_s2 + 1'b1) : rmag_s2;
			end
			error_code <= err_s2;
		end
	end

endmodule
